// ===== src/bsd_pkg.sv =====
// Shared constants for the box signed distance core.
// No dependencies.
package bsd_pkg;

   // Default coordinate width and fraction bits.
   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 8;

   // CSR register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_EXTENT_X = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_EXTENT_Y = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_EXTENT_Z = 2'd2;

endpackage

// ===== src/box_signed_distance_core.sv =====
// Box signed distance core: top level with CSRs, front end, square-root cell row, output.
// Depends on bsd_pkg, bsd_prep and bsd_sqrt_cell.

// Signed distance from a point to an origin-centred box, 8 fraction bits by default.
// A point moves in as one transfer on req_*; one distance comes back on rsp_*.
// Throughput is one point per clock while rsp_ready holds. A point passes through
// three front-end stages (|p| - b and clamp, squares, sum), one cell per root bit
// in the square-root row, and the output register that adds the inside term. Each
// stage stalls only while its own result is still held, so bubbles are squeezed
// out under back-pressure. Half-extents reset to 1.0; the user writes them through
// csr_* only while no point is in flight, which the block does not enforce; writes
// to an index beyond half_extent_z are ignored. The result never overflows its width.
module box_signed_distance_core #(
   parameter int COORD_WIDTH = bsd_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = bsd_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [COORD_WIDTH:0]         rsp_distance,
   input  logic                                csr_write,
   input  logic [bsd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-2:0]              csr_wdata
);
   import bsd_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int SW = 2 * CW;
   // 1.0 in the fixed-point format, cut to the register width
   localparam logic [CW-2:0] EXT_RESET = (CW-1)'(64'd1 << FRAC_BITS);

   // half-extent CSRs
   logic [CW-2:0] ext_x_ff, ext_y_ff, ext_z_ff;
   logic [CW-2:0] ext_x_in, ext_y_in, ext_z_in;

   always_comb begin
      ext_x_in = ext_x_ff;
      ext_y_in = ext_y_ff;
      ext_z_in = ext_z_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_HALF_EXTENT_X: ext_x_in = csr_wdata;
            CSR_HALF_EXTENT_Y: ext_y_in = csr_wdata;
            CSR_HALF_EXTENT_Z: ext_z_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_x_ff <= EXT_RESET;
         ext_y_ff <= EXT_RESET;
         ext_z_ff <= EXT_RESET;
      end else begin
         ext_x_ff <= ext_x_in;
         ext_y_ff <= ext_y_in;
         ext_z_ff <= ext_z_in;
      end
   end

   // links along the square-root row; link 0 is fed by the front end
   logic                 lk_valid  [0:CW];
   logic                 lk_ready  [0:CW];
   logic [SW-1:0]        lk_rad    [0:CW];
   logic [CW-1:0]        lk_rem    [0:CW];
   logic [CW-1:0]        lk_root   [0:CW];
   logic signed [CW:0]   lk_inside [0:CW];

   bsd_prep #(
      .COORD_WIDTH(CW)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (req_valid),
      .up_ready  (req_ready),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .ext_x     (ext_x_ff),
      .ext_y     (ext_y_ff),
      .ext_z     (ext_z_ff),
      .dn_valid  (lk_valid[0]),
      .dn_ready  (lk_ready[0]),
      .dn_sum    (lk_rad[0]),
      .dn_inside (lk_inside[0])
   );

   assign lk_rem[0]  = '0;
   assign lk_root[0] = '0;

   // one cell per root bit, most significant first
   for (genvar g = 0; g < CW; g++) begin : g_cell
      bsd_sqrt_cell #(
         .COORD_WIDTH(CW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_valid  (lk_valid[g]),
         .up_ready  (lk_ready[g]),
         .up_rad    (lk_rad[g]),
         .up_rem    (lk_rem[g]),
         .up_root   (lk_root[g]),
         .up_inside (lk_inside[g]),
         .dn_valid  (lk_valid[g+1]),
         .dn_ready  (lk_ready[g+1]),
         .dn_rad    (lk_rad[g+1]),
         .dn_rem    (lk_rem[g+1]),
         .dn_root   (lk_root[g+1]),
         .dn_inside (lk_inside[g+1])
      );
   end

   // output register: floor root plus inside term; one of the two is always zero
   logic                 out_valid_ff, out_valid_in;
   logic signed [CW:0]   dist_ff, dist_in;

   assign lk_ready[CW] = !out_valid_ff || rsp_ready;

   always_comb begin
      dist_in      = $signed({1'b0, lk_root[CW]}) + lk_inside[CW];
      out_valid_in = lk_ready[CW] ? lk_valid[CW] : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lk_ready[CW]) begin
         dist_ff <= dist_in;
      end
   end

   // final remainder and shifted-out radicand are unused
   assign rsp_valid    = out_valid_ff;
   assign rsp_distance = dist_ff;

endmodule

// ===== src/bsd_prep.sv =====
// Front end of the box distance pipeline: |p| - b, clamp, squares, sum of squares.
// Three registered stages with valid/ready. Uses bsd_pkg defaults.
module bsd_prep #(
   parameter int COORD_WIDTH = bsd_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic signed [COORD_WIDTH-1:0] pos_x,
   input  logic signed [COORD_WIDTH-1:0] pos_y,
   input  logic signed [COORD_WIDTH-1:0] pos_z,
   input  logic [COORD_WIDTH-2:0]        ext_x,
   input  logic [COORD_WIDTH-2:0]        ext_y,
   input  logic [COORD_WIDTH-2:0]        ext_z,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output logic [2*COORD_WIDTH-1:0]      dn_sum,
   output logic signed [COORD_WIDTH:0]   dn_inside
);
   import bsd_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int SW = 2 * CW;

   // stage A: clamped outside components and inside term
   logic                  a_valid_ff, a_valid_in, a_ready;
   logic [CW-1:0]         ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic signed [CW:0]    ia_ff, ia_in;
   // stage B: squares
   logic                  b_valid_ff, b_valid_in, b_ready;
   logic [SW-2:0]         sx_ff, sy_ff, sz_ff;
   logic signed [CW:0]    ib_ff;
   // stage C: sum of squares
   logic                  c_valid_ff, c_valid_in, c_ready;
   logic [SW-1:0]         sum_ff, sum_in;
   logic signed [CW:0]    ic_ff;

   logic [CW-1:0]         mx, my, mz;
   logic signed [CW:0]    qx, qy, qz, qmax;
   logic [SW-1:0]         px, py, pz;

   assign c_ready  = !c_valid_ff || dn_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign up_ready = a_ready;

   always_comb begin
      // the most negative code negates onto itself, which is the right magnitude
      mx = pos_x[CW-1] ? CW'(-pos_x) : CW'(pos_x);
      my = pos_y[CW-1] ? CW'(-pos_y) : CW'(pos_y);
      mz = pos_z[CW-1] ? CW'(-pos_z) : CW'(pos_z);
      qx = $signed({1'b0, mx}) - $signed({2'b00, ext_x});
      qy = $signed({1'b0, my}) - $signed({2'b00, ext_y});
      qz = $signed({1'b0, mz}) - $signed({2'b00, ext_z});
      ox_in = (qx > 0) ? qx[CW-1:0] : '0;
      oy_in = (qy > 0) ? qy[CW-1:0] : '0;
      oz_in = (qz > 0) ? qz[CW-1:0] : '0;
      qmax = qx;
      if (qy > qmax) begin
         qmax = qy;
      end
      if (qz > qmax) begin
         qmax = qz;
      end
      ia_in = (qmax < 0) ? qmax : '0;

      px = ox_ff * ox_ff;
      py = oy_ff * oy_ff;
      pz = oz_ff * oz_ff;

      sum_in = {1'b0, sx_ff} + {1'b0, sy_ff} + {1'b0, sz_ff};

      a_valid_in = a_ready ? up_valid : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      c_valid_in = c_ready ? b_valid_ff : c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         oz_ff <= oz_in;
         ia_ff <= ia_in;
      end
      if (b_ready) begin
         sx_ff <= px[SW-2:0];
         sy_ff <= py[SW-2:0];
         sz_ff <= pz[SW-2:0];
         ib_ff <= ia_ff;
      end
      if (c_ready) begin
         sum_ff <= sum_in;
         ic_ff  <= ib_ff;
      end
   end

   assign dn_valid  = c_valid_ff;
   assign dn_sum    = sum_ff;
   assign dn_inside = ic_ff;

endmodule

// ===== src/bsd_sqrt_cell.sv =====
// One cell of the square-root row: settles one root bit from two radicand bits.
// Registered, valid/ready to its neighbours. No package dependencies.
module bsd_sqrt_cell #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic [2*COORD_WIDTH-1:0]      up_rad,
   input  logic [COORD_WIDTH-1:0]        up_rem,
   input  logic [COORD_WIDTH-1:0]        up_root,
   input  logic signed [COORD_WIDTH:0]   up_inside,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output logic [2*COORD_WIDTH-1:0]      dn_rad,
   output logic [COORD_WIDTH-1:0]        dn_rem,
   output logic [COORD_WIDTH-1:0]        dn_root,
   output logic signed [COORD_WIDTH:0]   dn_inside
);
   localparam int CW = COORD_WIDTH;
   localparam int SW = 2 * CW;

   logic                 valid_ff, valid_in;
   logic [SW-1:0]        rad_ff, rad_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [CW-1:0]        root_ff, root_in;
   logic signed [CW:0]   inside_ff;
   logic [CW+1:0]        rem_cat, trial, diff;
   logic                 take;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      // remainder stays below 2^CW until the last bit, whose remainder is dropped
      rem_cat  = {up_rem, up_rad[SW-1:SW-2]};
      trial    = {up_root, 2'b01};
      diff     = rem_cat - trial;
      take     = (rem_cat >= trial);
      rem_in   = take ? diff[CW-1:0] : rem_cat[CW-1:0];
      root_in  = {up_root[CW-2:0], take};
      rad_in   = {up_rad[SW-3:0], 2'b00};
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         rad_ff    <= rad_in;
         rem_ff    <= rem_in;
         root_ff   <= root_in;
         inside_ff <= up_inside;
      end
   end

   assign dn_valid  = valid_ff;
   assign dn_rad    = rad_ff;
   assign dn_rem    = rem_ff;
   assign dn_root   = root_ff;
   assign dn_inside = inside_ff;

endmodule

// ===== src/bsd_checker.sv =====
// Port-level checks for box_signed_distance_core, bound to the top level.
// No package dependencies.
module bsd_checker #(
   parameter int COORD_WIDTH = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [COORD_WIDTH:0]   rsp_distance
);
   localparam logic signed [COORD_WIDTH:0] MIN_DIST =
      -$signed({2'b00, {(COORD_WIDTH-1){1'b1}}});

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
      else $error("result changed while stalled");

   // deepest inside distance is no lower than minus the largest half-extent code
   a_rsp_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance >= MIN_DIST)
      else $error("distance below range");

   // nothing comes out straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // with the output stage empty, ready runs back through the whole row
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input refused with empty output stage");

endmodule

bind box_signed_distance_core bsd_checker #(
   .COORD_WIDTH(COORD_WIDTH)
) u_bsd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_distance (rsp_distance)
);
